// ===== design/swd_pkg.sv =====
package swd_pkg;

  localparam int ANGLE_W = 12;
  localparam int DIST_W  = 16;
  localparam int POS_W   = 16;
  localparam int TRIG_W  = 5;
  localparam int GAP_W   = 16;
  localparam int LIMIT_W = 34;
  localparam int MOOD_W  = 2;
  localparam int SOUND_W = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 34;

  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_TRIG    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SOUND_GAP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_SQ  = 3'd5;

  localparam logic [ANGLE_W-1:0] RST_SECTOR_LOW  = 12'd700;
  localparam logic [ANGLE_W-1:0] RST_SECTOR_HIGH = 12'd2900;
  localparam logic [DIST_W-1:0]  RST_NEAR_THR    = 16'd70;
  localparam logic [TRIG_W-1:0]  RST_WIN_TRIG    = 5'd10;
  localparam logic [GAP_W-1:0]   RST_SOUND_GAP   = 16'd5;
  localparam logic [LIMIT_W-1:0] RST_RECOVER_SQ  = 34'd10000;

  localparam logic [SOUND_W-1:0] SND_NONE = 2'd0;
  localparam logic [SOUND_W-1:0] SND_ESC  = 2'd1;
  localparam logic [SOUND_W-1:0] SND_REC  = 2'd2;

  localparam logic [GAP_W-1:0] TICKS_MAX = 16'hFFFF;

  localparam int ACT_BEAM = 0;
  localparam int ACT_TICK = 1;

endpackage

// ===== design/swd_ring.sv =====
module swd_ring import swd_pkg::*; #(
  parameter int WINDOW_LEN = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              close_i,
  input  logic              blocked_i,
  input  logic [TRIG_W-1:0] trigger_i,
  output logic              stuck_o
);

  localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int CMP_W = (CNT_W > TRIG_W) ? CNT_W : TRIG_W;

  logic [WINDOW_LEN-1:0] ring_q, ring_d;
  logic [PTR_W-1:0]      ptr_q, ptr_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      cnt_sum;
  logic [CMP_W-1:0]      cnt_ext, trig_ext;
  logic                  stuck;

  always_comb begin
    cnt_sum  = cnt_q - CNT_W'(ring_q[ptr_q]) + CNT_W'(blocked_i);
    cnt_ext  = CMP_W'(cnt_sum);
    trig_ext = CMP_W'(trigger_i);
    stuck    = close_i && (cnt_ext > trig_ext);
    ring_d   = ring_q;
    ptr_d    = ptr_q;
    cnt_d    = cnt_q;
    if (close_i) begin
      ring_d[ptr_q] = blocked_i;
      cnt_d         = cnt_sum;
      ptr_d         = (ptr_q == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_q + 1'b1;
      if (stuck) begin
        ring_d = '0;
        cnt_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q <= '0;
      ptr_q  <= '0;
      cnt_q  <= '0;
    end else begin
      ring_q <= ring_d;
      ptr_q  <= ptr_d;
      cnt_q  <= cnt_d;
    end
  end

  assign stuck_o = stuck;

endmodule

// ===== design/stuck_window_detector_unit.sv =====
// A request accepted into the input register shows its result from the result register.
// Throughput: one request per cycle while the output is not stalled; the state update of each
// request completes in the single pass from the input register to the result register.
// A stalled output that holds a valid result also stalls the input side.
// Reset: configuration registers return to their defaults; scan ring, counters, mood and the
// recorded position clear at once; no clearing pass.
module stuck_window_detector_unit import swd_pkg::*; #(
  parameter int WINDOW_LEN  = 20,
  parameter int MOOD_LEVELS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  action_i,
  input  logic [ANGLE_W-1:0]    beam_angle_i,
  input  logic [DIST_W-1:0]     beam_distance_i,
  input  logic                  last_beam_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  scan_done_o,
  output logic                  stuck_o,
  output logic [MOOD_W-1:0]     mood_o,
  output logic [SOUND_W-1:0]    sound_o
);

  localparam int MOOD_RAW = (MOOD_LEVELS > 1) ? MOOD_LEVELS - 1 : 0;
  localparam logic [MOOD_W-1:0] MOOD_TOP = (MOOD_RAW > 3) ? 2'd3 : MOOD_W'(MOOD_RAW);

  logic [ANGLE_W-1:0] sec_low_q, sec_high_q;
  logic [DIST_W-1:0]  near_thr_q;
  logic [TRIG_W-1:0]  win_trig_q;
  logic [GAP_W-1:0]   gap_q;
  logic [LIMIT_W-1:0] limit_q;

  logic                  in_vld_q;
  logic                  act_q, last_q;
  logic [ANGLE_W-1:0]    angle_q;
  logic [DIST_W-1:0]     dist_q;
  logic signed [POS_W-1:0] px_q, py_q;

  logic                  out_vld_q;
  logic                  done_q, stuck_q;
  logic [SOUND_W-1:0]    sound_q;

  logic                  blocked_q, blocked_d;
  logic [GAP_W-1:0]      ticks_q, ticks_d;
  logic [MOOD_W-1:0]     mood_q, mood_d;
  logic signed [POS_W-1:0] spx_q, spx_d, spy_q, spy_d;

  logic                  accept, advance;
  logic                  beam_hit, scan_blk, close, ring_stuck;
  logic [SOUND_W-1:0]    sound_d;
  logic signed [POS_W:0]   dx, dy;
  logic signed [LIMIT_W-1:0] sq_x, sq_y;
  logic [LIMIT_W-1:0]    d2;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_low_q  <= RST_SECTOR_LOW;
      sec_high_q <= RST_SECTOR_HIGH;
      near_thr_q <= RST_NEAR_THR;
      win_trig_q <= RST_WIN_TRIG;
      gap_q      <= RST_SOUND_GAP;
      limit_q    <= RST_RECOVER_SQ;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SECTOR_LOW:  sec_low_q  <= cfg_data_i[ANGLE_W-1:0];
        CFG_SECTOR_HIGH: sec_high_q <= cfg_data_i[ANGLE_W-1:0];
        CFG_NEAR_THR:    near_thr_q <= cfg_data_i[DIST_W-1:0];
        CFG_WIN_TRIG:    win_trig_q <= cfg_data_i[TRIG_W-1:0];
        CFG_SOUND_GAP:   gap_q      <= cfg_data_i[GAP_W-1:0];
        CFG_RECOVER_SQ:  limit_q    <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= action_i;
      angle_q <= beam_angle_i;
      dist_q  <= beam_distance_i;
      last_q  <= last_beam_i;
      px_q    <= pos_x_i;
      py_q    <= pos_y_i;
    end
  end

  assign beam_hit = (angle_q < sec_low_q || angle_q > sec_high_q) &&
                    (dist_q != '0) && (dist_q < near_thr_q);
  assign scan_blk = blocked_q || beam_hit;
  assign close    = advance && (act_q == 1'(ACT_BEAM)) && last_q;

  swd_ring #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .close_i  (close),
    .blocked_i(scan_blk),
    .trigger_i(win_trig_q),
    .stuck_o  (ring_stuck)
  );

  always_comb begin
    dx   = {px_q[POS_W-1], px_q} - {spx_q[POS_W-1], spx_q};
    dy   = {py_q[POS_W-1], py_q} - {spy_q[POS_W-1], spy_q};
    sq_x = dx * dx;
    sq_y = dy * dy;
    d2   = $unsigned(sq_x) + $unsigned(sq_y);
  end

  always_comb begin
    blocked_d = blocked_q;
    ticks_d   = ticks_q;
    mood_d    = mood_q;
    spx_d     = spx_q;
    spy_d     = spy_q;
    sound_d   = SND_NONE;
    if (advance) begin
      if (act_q == 1'(ACT_TICK)) begin
        if (ticks_q != TICKS_MAX) begin
          ticks_d = ticks_q + 1'b1;
        end
      end else if (!last_q) begin
        blocked_d = scan_blk;
      end else begin
        blocked_d = 1'b0;
        if (ring_stuck) begin
          spx_d = px_q;
          spy_d = py_q;
          if (ticks_q > gap_q) begin
            ticks_d = '0;
            sound_d = SND_ESC;
            if (mood_q < MOOD_TOP) begin
              mood_d = mood_q + 1'b1;
            end
          end
        end else if (mood_q != '0 && d2 > limit_q) begin
          mood_d  = '0;
          sound_d = SND_REC;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocked_q <= 1'b0;
      ticks_q   <= '0;
      mood_q    <= '0;
      spx_q     <= '0;
      spy_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      blocked_q <= blocked_d;
      ticks_q   <= ticks_d;
      mood_q    <= mood_d;
      spx_q     <= spx_d;
      spy_q     <= spy_d;
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      done_q  <= close;
      stuck_q <= ring_stuck;
      sound_q <= sound_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign scan_done_o = done_q;
  assign stuck_o     = stuck_q;
  assign sound_o     = sound_q;
  assign mood_o      = mood_q;

`ifndef SYNTH
  a_stuck_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stuck_o |-> scan_done_o)
    else $error("stuck without closed scan");

  a_esc_on_stuck: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sound_o == SND_ESC |-> stuck_o && mood_o != '0)
    else $error("escalation sound without stuck");

  a_rec_calm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sound_o == SND_REC |-> mood_o == '0 && !stuck_o)
    else $error("recovery sound with raised mood");

  a_mood_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mood_q <= MOOD_TOP)
    else $error("mood above top level");
`endif

endmodule

// ===== tb/sv/swd_verdict_monitor.sv =====
`timescale 1ns / 100ps
module swd_verdict_monitor import swd_pkg::*; #(
  parameter int WINDOW_LEN  = 20,
  parameter int MOOD_LEVELS = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic                    action_i,
  input  logic [ANGLE_W-1:0]      beam_angle_i,
  input  logic [DIST_W-1:0]       beam_distance_i,
  input  logic                    last_beam_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic                    scan_done_i,
  input  logic                    stuck_i,
  input  logic [MOOD_W-1:0]       mood_i,
  input  logic [SOUND_W-1:0]      sound_i,
  input  logic                    drain_check_i,
  output int                      pending_o,
  output int                      failures_o
);

  localparam int TOP_MOOD = (MOOD_LEVELS - 1 > 3) ? 3 : MOOD_LEVELS - 1;

  typedef struct packed {
    logic               scan_done;
    logic               stuck;
    logic [MOOD_W-1:0]  mood;
    logic [SOUND_W-1:0] sound;
  } verdict_t;

  logic [ANGLE_W-1:0]      sec_lo;
  logic [ANGLE_W-1:0]      sec_hi;
  logic [DIST_W-1:0]       near_thr;
  logic [TRIG_W-1:0]       win_trig;
  logic [GAP_W-1:0]        sound_gap;
  logic [LIMIT_W-1:0]      calm_limit;

  logic                    scan_hit;
  logic [WINDOW_LEN-1:0]   hit_ring;
  int unsigned             ring_ptr;
  logic [GAP_W-1:0]        quiet_ticks;
  logic [MOOD_W-1:0]       mood;
  logic signed [POS_W-1:0] anchor_x;
  logic signed [POS_W-1:0] anchor_y;

  verdict_t                verdict_q[$];
  int                      report_cnt;
  int unsigned             result_idx;
  logic                    drained;

  function automatic verdict_t judge_request(
    logic act, logic [ANGLE_W-1:0] ang, logic [DIST_W-1:0] dist_cm, logic last,
    logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py);
    verdict_t           v;
    int unsigned        hits;
    longint             dx;
    longint             dy;
    longint unsigned    d2;
    v = '0;
    if (act == ACT_TICK) begin
      if (quiet_ticks != TICKS_MAX) quiet_ticks++;
    end else begin
      if ((ang < sec_lo || ang > sec_hi) && dist_cm != '0 && dist_cm < near_thr)
        scan_hit = 1'b1;
      if (last) begin
        v.scan_done = 1'b1;
        if (ring_ptr >= WINDOW_LEN) ring_ptr = 0;
        hit_ring[ring_ptr] = scan_hit;
        hits = $countones(hit_ring);
        if (hits > int'(win_trig)) begin
          v.stuck = 1'b1;
          hit_ring = '0;
          if (quiet_ticks > sound_gap) begin
            if (int'(mood) < TOP_MOOD) mood++;
            v.sound = SND_ESC;
            quiet_ticks = '0;
          end
          anchor_x = px;
          anchor_y = py;
        end
        ring_ptr = (ring_ptr + 1) % WINDOW_LEN;
        scan_hit = 1'b0;
        if (mood != '0) begin
          dx = longint'(px) - longint'(anchor_x);
          dy = longint'(py) - longint'(anchor_y);
          d2 = longint'(dx * dx) + longint'(dy * dy);
          if (d2 > longint'(calm_limit)) begin
            mood = '0;
            v.sound = SND_REC;
          end
        end
      end
    end
    v.mood = mood;
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      sec_lo      = RST_SECTOR_LOW;
      sec_hi      = RST_SECTOR_HIGH;
      near_thr    = RST_NEAR_THR;
      win_trig    = RST_WIN_TRIG;
      sound_gap   = RST_SOUND_GAP;
      calm_limit  = RST_RECOVER_SQ;
      scan_hit    = 1'b0;
      hit_ring    = '0;
      ring_ptr    = 0;
      quiet_ticks = '0;
      mood        = '0;
      anchor_x    = '0;
      anchor_y    = '0;
      verdict_q.delete();
      report_cnt  = 0;
      result_idx  = 0;
      drained     = 1'b0;
      failures_o  = 0;
      pending_o  <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          failures_o++;
          if (report_cnt < 10) begin
            report_cnt++;
            $display("%0t: result %0d arrived with no request outstanding", $realtime,
                     result_idx);
          end
        end else begin
          want = verdict_q.pop_front();
          if (scan_done_i !== want.scan_done || stuck_i !== want.stuck ||
              mood_i !== want.mood || sound_i !== want.sound) begin
            failures_o++;
            if (report_cnt < 10) begin
              report_cnt++;
              $display("%0t: result %0d expected done=%0b stuck=%0b mood=%0d sound=%0d",
                       $realtime, result_idx, want.scan_done, want.stuck, want.mood,
                       want.sound);
              $display("%0t: result %0d actual   done=%0b stuck=%0b mood=%0d sound=%0d",
                       $realtime, result_idx, scan_done_i, stuck_i, mood_i, sound_i);
            end
          end
        end
        result_idx++;
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SECTOR_LOW:  sec_lo     = cfg_data_i[ANGLE_W-1:0];
          CFG_SECTOR_HIGH: sec_hi     = cfg_data_i[ANGLE_W-1:0];
          CFG_NEAR_THR:    near_thr   = cfg_data_i[DIST_W-1:0];
          CFG_WIN_TRIG:    win_trig   = cfg_data_i[TRIG_W-1:0];
          CFG_SOUND_GAP:   sound_gap  = cfg_data_i[GAP_W-1:0];
          CFG_RECOVER_SQ:  calm_limit = cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        verdict_q.push_back(judge_request(action_i, beam_angle_i, beam_distance_i,
                                          last_beam_i, pos_x_i, pos_y_i));
      end

      if (drain_check_i && !drained) begin
        drained = 1'b1;
        if (verdict_q.size() != 0) begin
          failures_o += verdict_q.size();
          $display("%0t: %0d results never arrived", $realtime, verdict_q.size());
        end
      end

      pending_o <= verdict_q.size();
    end
  end

endmodule

// ===== tb/sv/stuck_window_detector_unit_tb.sv =====
`timescale 1ns / 100ps
module stuck_window_detector_unit_tb;
  import swd_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 300;

  typedef struct packed {
    logic                    act;
    logic [ANGLE_W-1:0]      angle;
    logic [DIST_W-1:0]       dist_cm;
    logic                    last;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } beam_req_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i      = '0;
  logic                    in_valid_i      = 1'b0;
  logic                    in_stall_o;
  logic                    action_i        = 1'b0;
  logic [ANGLE_W-1:0]      beam_angle_i    = '0;
  logic [DIST_W-1:0]       beam_distance_i = '0;
  logic                    last_beam_i     = 1'b0;
  logic signed [POS_W-1:0] pos_x_i         = '0;
  logic signed [POS_W-1:0] pos_y_i         = '0;
  logic                    out_valid_o;
  logic                    out_stall_i     = 1'b0;
  logic                    scan_done_o;
  logic                    stuck_o;
  logic [MOOD_W-1:0]       mood_o;
  logic [SOUND_W-1:0]      sound_o;
  logic                    drain_check     = 1'b0;
  int                      pending;
  int                      failures;

  int unsigned             send_idle_pct = 0;
  int unsigned             recv_idle_pct = 0;
  int unsigned             items_sent    = 0;
  int unsigned             cur_near      = 0;
  int                      quiet_cycles  = 0;
  logic signed [POS_W-1:0] rx = '0;
  logic signed [POS_W-1:0] ry = '0;

  stuck_window_detector_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .beam_angle_i    (beam_angle_i),
    .beam_distance_i (beam_distance_i),
    .last_beam_i     (last_beam_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .scan_done_o     (scan_done_o),
    .stuck_o         (stuck_o),
    .mood_o          (mood_o),
    .sound_o         (sound_o)
  );

  swd_verdict_monitor monitor_u (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .action_i        (action_i),
    .beam_angle_i    (beam_angle_i),
    .beam_distance_i (beam_distance_i),
    .last_beam_i     (last_beam_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .scan_done_i     (scan_done_o),
    .stuck_i         (stuck_o),
    .mood_i          (mood_o),
    .sound_i         (sound_o),
    .drain_check_i   (drain_check),
    .pending_o       (pending),
    .failures_o      (failures)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic offer(input beam_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= r.act;
    beam_angle_i    <= r.angle;
    beam_distance_i <= r.dist_cm;
    last_beam_i     <= r.last;
    pos_x_i         <= r.x;
    pos_y_i         <= r.y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic tick();
    beam_req_t r;
    r.act     = 1'(ACT_TICK);
    r.angle   = ANGLE_W'($urandom_range(3599));
    r.dist_cm = DIST_W'($urandom_range(65535));
    r.last    = 1'($urandom_range(1));
    r.x       = POS_W'($urandom_range(65535));
    r.y       = POS_W'($urandom_range(65535));
    offer(r);
  endtask

  task automatic beam(input int unsigned ang, input int unsigned dist_cm, input bit last,
                      input int px, input int py);
    beam_req_t r;
    r.act     = 1'(ACT_BEAM);
    r.angle   = ANGLE_W'(ang);
    r.dist_cm = DIST_W'(dist_cm);
    r.last    = last;
    r.x       = POS_W'(px);
    r.y       = POS_W'(py);
    offer(r);
  endtask

  function automatic beam_req_t rand_beam(bit is_last);
    beam_req_t   r;
    int unsigned reach;
    reach     = (cur_near + 3 > 65535) ? 65535 : cur_near + 3;
    r.act     = 1'(ACT_BEAM);
    r.angle   = ANGLE_W'($urandom_range(3599));
    r.dist_cm = ($urandom_range(99) < 40) ? DIST_W'($urandom_range(reach))
                                          : DIST_W'($urandom_range(65535));
    r.last    = is_last;
    r.x       = is_last ? rx : POS_W'($urandom_range(65535));
    r.y       = is_last ? ry : POS_W'($urandom_range(65535));
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] nudge(logic signed [POS_W-1:0] v);
    int n;
    n = int'(v) + int'($urandom_range(120)) - 60;
    if (n > 32767) n = 32767;
    if (n < -32768) n = -32768;
    return POS_W'(n);
  endfunction

  // hold until every result is back, then let the pipeline empty
  task automatic settle();
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic load_settings(input longint unsigned lo, input longint unsigned hi,
                               input longint unsigned near, input longint unsigned trig,
                               input longint unsigned gap, input longint unsigned calm);
    longint unsigned vals[6];
    logic [CFG_IDX_W-1:0] idx[6];
    vals = '{lo, hi, near, trig, gap, calm};
    idx  = '{CFG_SECTOR_LOW, CFG_SECTOR_HIGH, CFG_NEAR_THR, CFG_WIN_TRIG, CFG_SOUND_GAP,
             CFG_RECOVER_SQ};
    for (int k = 0; k < 6; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= CFG_DATA_W'(vals[k]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_near = int'(near);
  endtask

  task automatic random_phase(input int unsigned n_items);
    int unsigned start;
    int unsigned beams;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(99) < 40) repeat ($urandom_range(4, 1)) tick();
      case ($urandom_range(9))
        0: begin
          rx = POS_W'($urandom_range(65535));
          ry = POS_W'($urandom_range(65535));
        end
        1, 2: ;
        default: begin
          rx = nudge(rx);
          ry = nudge(ry);
        end
      endcase
      beams = $urandom_range(6, 1);
      for (int unsigned k = 1; k <= beams; k++) offer(rand_beam(k == beams));
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic phase_settings(input int p);
    case (p)
      0: load_settings(700, 2900, 70, 3, 5, 10000);
      1: load_settings(3599, 0, 65535, 1, 65535, 64'd17179869183);
      2: load_settings(1800, 1800, 200, 0, 2, 0);
      3: load_settings(0, 3000, 65535, 5, 1, 400000);
      4: load_settings(1200, 2400, 1000, 2, 10, 2500000);
      default: load_settings(2000, 100, 0, 20, 3, 10000);
    endcase
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 27;
    recv_idle_pct = 64;
    settle();

    load_settings(700, 2900, 70, 0, 1, 10000);
    beam(0, 0, 0, 5, 5);
    beam(700, 10, 1, 0, 0);
    beam(2900, 10, 1, 0, 0);
    beam(699, 69, 1, 100, 0);
    tick();
    tick();
    beam(3599, 1, 1, -32768, 32767);
    beam(2901, 65535, 0, 0, 0);
    beam(3000, 100, 1, 32767, -32768);
    for (int k = 0; k < 4; k++) begin
      tick();
      tick();
      beam(100 * k, 1 + k, 1, 0, 0);
    end
    beam(1500, 1, 1, 30, 40);
    beam(1500, 1, 1, 100, 0);
    beam(1500, 1, 1, 100, 1);
    in_valid_i <= 1'b0;

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 64;
        recv_idle_pct = 27;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      settle();
      phase_settings(p);
      random_phase(PHASE_ITEMS);
    end

    while (pending != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    drain_check <= 1'b1;
    repeat (3) @(posedge clk_i);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== stuck_window_detector_unit.f =====
design/swd_pkg.sv
design/swd_ring.sv
design/stuck_window_detector_unit.sv
tb/sv/swd_verdict_monitor.sv
tb/sv/stuck_window_detector_unit_tb.sv
